// ===== rtl/uirb_pkg.sv =====
// Package for the UART interrupt ring buffers: request and result structs,
// command, kind and status codes, and the controller state type.
// No dependencies.
package uirb_pkg;

  localparam int UIRB_RING_DEPTH = 256;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] CMD_PUT      = 2'd0;
  localparam logic [1:0] CMD_GET      = 2'd1;
  localparam logic [1:0] CMD_RX_EVENT = 2'd2;
  localparam logic [1:0] CMD_TX_READY = 2'd3;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_LINE   = 2'd1;
  localparam logic [1:0] KIND_CONSUMER = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       rx_irq_enable;
    logic       tx_irq_enable;
    logic [7:0] rx_fill;
    logic [7:0] tx_fill;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] din;
  } ring_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/uirb_cell.sv =====
// One byte cell of a ring chain: loads a new byte or takes its neighbor's.
// Depends on nothing but the clock.
module uirb_cell (
  input  logic       clk,
  input  logic       load,
  input  logic       shift,
  input  logic [7:0] din,
  input  logic [7:0] nbr,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= din;
    end else if (shift) begin
      q <= nbr;
    end
  end

endmodule

// ===== rtl/uirb_ring.sv =====
// Byte queue built as a row of uirb_cell stages with a fill count.
// Depends on uirb_pkg and uirb_cell.
module uirb_ring import uirb_pkg::*; #(
  parameter int RING_DEPTH = UIRB_RING_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ring_ctrl_t                    ctrl,
  output logic [7:0]                    head,
  output logic [$clog2(RING_DEPTH)-1:0] count,
  output logic                          full,
  output logic                          empty
);

  localparam int CW    = $clog2(RING_DEPTH);
  localparam int NCELL = RING_DEPTH - 1;

  logic [7:0] q [NCELL];

  // A push lands in the first free cell; a pop moves every cell one step
  // toward the head, so the oldest byte always sits in cell zero.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [7:0] nbr;
    if (i == NCELL - 1) begin : g_end
      assign nbr = 8'h00;
    end else begin : g_mid
      assign nbr = q[i+1];
    end
    uirb_cell u_cell (
      .clk   (clk),
      .load  (ctrl.push && (count == CW'(i))),
      .shift (ctrl.pop),
      .din   (ctrl.din),
      .nbr   (nbr),
      .q     (q[i])
    );
  end

  assign head  = q[0];
  assign full  = (count == CW'(NCELL));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + CW'(1);
    end else if (ctrl.pop) begin
      count <= count - CW'(1);
    end
  end

endmodule

// ===== rtl/uart_irq_ring_buffers.sv =====
// Top level: command decoder, interrupt-enable bits, result sequencer and the
// transmit and receive rings. Depends on uirb_pkg and uirb_ring.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_ready       in_data (in_item_t)
//   out      output     out_valid / out_ready     out_data (out_item_t)
//   cfg      input      cfg_wr_en                 cfg_wr_data (echo enable)
//
// A request is taken while idle, then each of its results is offered in turn,
// one per cycle while out_ready is high: an echoed carriage return gives three
// results, any other request one. The result sequencer walks the results of one request.
// Reset clears the fill counts and the interrupt-enable bits and turns echo
// on; ring contents are not cleared. A stalled result holds, and no request
// is taken until the last result of the previous one has been taken.
module uart_irq_ring_buffers import uirb_pkg::*; #(
  parameter int RING_DEPTH = UIRB_RING_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int CW = $clog2(RING_DEPTH);
  localparam int FW = (CW > 8) ? CW : 8;

  state_t state, state_next;

  ring_ctrl_t       rx_ctrl, tx_ctrl;
  logic [7:0]       rx_head, tx_head;
  logic [CW-1:0]    rx_count, tx_count;
  logic             rx_full, rx_empty, tx_full, tx_empty;

  logic             echo_enable;
  logic             rx_ie, tx_ie, rx_ie_next, tx_ie_next;
  logic [1:0]       res_kind, res_kind_next;
  logic [1:0]       res_status, res_status_next;
  logic [7:0]       res_byte, res_byte_next;
  logic [1:0]       res_n, res_n_next;
  logic [7:0]       rx_fill, rx_fill_next, tx_fill, tx_fill_next;
  logic [1:0]       res_k;

  logic             in_acc, out_acc, res_last;
  logic [CW-1:0]    rx_cnt_after, tx_cnt_after;
  logic [FW-1:0]    rx_cnt_wide, tx_cnt_wide;

  uirb_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (rx_ctrl),
    .head  (rx_head),
    .count (rx_count),
    .full  (rx_full),
    .empty (rx_empty)
  );

  uirb_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (tx_ctrl),
    .head  (tx_head),
    .count (tx_count),
    .full  (tx_full),
    .empty (tx_empty)
  );

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign res_last = (res_k == (res_n - 2'd1));

  // Decode of the request at the cycle it is taken.
  always_comb begin
    rx_ctrl         = '{push: 1'b0, pop: 1'b0, din: in_data.data_byte};
    tx_ctrl         = '{push: 1'b0, pop: 1'b0, din: in_data.data_byte};
    rx_ie_next      = rx_ie;
    tx_ie_next      = tx_ie;
    res_kind_next   = KIND_STATUS;
    res_status_next = STATUS_DONE;
    res_byte_next   = 8'h00;
    res_n_next      = 2'd1;
    case (in_data.command)
      CMD_PUT: begin
        tx_ie_next = 1'b1;
        if (tx_full) begin
          res_status_next = STATUS_FULL;
        end else begin
          tx_ctrl.push = in_acc;
        end
      end
      CMD_GET: begin
        rx_ie_next = 1'b1;
        if (rx_empty) begin
          res_status_next = STATUS_EMPTY;
        end else begin
          rx_ctrl.pop   = in_acc;
          res_kind_next = KIND_CONSUMER;
          res_byte_next = rx_head;
        end
      end
      CMD_RX_EVENT: begin
        if (rx_full) begin
          rx_ie_next      = 1'b0;
          res_status_next = STATUS_FULL;
        end else begin
          rx_ie_next   = 1'b1;
          rx_ctrl.push = in_acc;
          if (in_data.data_byte == CH_CR) begin
            rx_ctrl.din = CH_LF;
          end
          if (echo_enable) begin
            res_kind_next = KIND_LINE;
            res_byte_next = in_data.data_byte;
            if (in_data.data_byte == CH_CR) begin
              res_n_next = 2'd3;
            end
          end
        end
      end
      default: begin
        if (tx_empty) begin
          tx_ie_next      = 1'b0;
          res_status_next = STATUS_EMPTY;
        end else begin
          tx_ie_next    = 1'b1;
          tx_ctrl.pop   = in_acc;
          res_kind_next = KIND_LINE;
          res_byte_next = tx_head;
        end
      end
    endcase
  end

  // Fill after the step, clamped to the width of the field.
  always_comb begin
    rx_cnt_after = rx_count;
    tx_cnt_after = tx_count;
    if (rx_ctrl.push) begin
      rx_cnt_after = rx_count + CW'(1);
    end else if (rx_ctrl.pop) begin
      rx_cnt_after = rx_count - CW'(1);
    end
    if (tx_ctrl.push) begin
      tx_cnt_after = tx_count + CW'(1);
    end else if (tx_ctrl.pop) begin
      tx_cnt_after = tx_count - CW'(1);
    end
    rx_cnt_wide  = FW'(rx_cnt_after);
    tx_cnt_wide  = FW'(tx_cnt_after);
    rx_fill_next = (rx_cnt_wide > FW'(255)) ? 8'hFF : rx_cnt_wide[7:0];
    tx_fill_next = (tx_cnt_wide > FW'(255)) ? 8'hFF : tx_cnt_wide[7:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && res_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: in_ready  = 1'b1;
      ST_EMIT: out_valid = 1'b1;
      default: in_ready  = 1'b0;
    endcase
  end

  always_comb begin
    out_data.kind          = res_kind;
    out_data.status        = res_status;
    out_data.rx_irq_enable = rx_ie;
    out_data.tx_irq_enable = tx_ie;
    out_data.rx_fill       = rx_fill;
    out_data.tx_fill       = tx_fill;
    out_data.last          = res_last;
    case (res_k)
      2'd0:    out_data.out_byte = res_byte;
      2'd1:    out_data.out_byte = CH_CR;
      default: out_data.out_byte = CH_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      echo_enable <= 1'b1;
      rx_ie       <= 1'b0;
      tx_ie       <= 1'b0;
      res_k       <= 2'd0;
      res_n       <= 2'd1;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        echo_enable <= cfg_wr_data;
      end
      if (in_acc) begin
        rx_ie <= rx_ie_next;
        tx_ie <= tx_ie_next;
        res_n <= res_n_next;
        res_k <= 2'd0;
      end else if (out_acc) begin
        res_k <= res_k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_kind   <= res_kind_next;
      res_status <= res_status_next;
      res_byte   <= res_byte_next;
      rx_fill    <= rx_fill_next;
      tx_fill    <= tx_fill_next;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for uart_irq_ring_buffers: drives put, get, rx_event and tx_ready
// requests and checks every result against a scoreboard that predicts both rings.
// Depends on uirb_pkg and the uart_irq_ring_buffers RTL.
`timescale 1ns / 100ps

import uirb_pkg::*;

class ring_scoreboard;
  logic [7:0]  rx_store [UIRB_RING_DEPTH];
  logic [7:0]  tx_store [UIRB_RING_DEPTH];
  int unsigned rx_wr, rx_rd, tx_wr, tx_rd;
  bit          rx_ie, tx_ie, echo_on;
  out_item_t   pending_results[$];
  int          errors, n_requests, n_checked;
  int          n_full, n_empty, n_cr_echo;

  function new();
    rx_wr = 0;
    rx_rd = 0;
    tx_wr = 0;
    tx_rd = 0;
    rx_ie = 1'b0;
    tx_ie = 1'b0;
    echo_on = 1'b1;
    errors = 0;
    n_requests = 0;
    n_checked = 0;
    n_full = 0;
    n_empty = 0;
    n_cr_echo = 0;
  endfunction

  function int unsigned next_slot(int unsigned p);
    return (p + 1 >= UIRB_RING_DEPTH) ? 0 : p + 1;
  endfunction

  function int unsigned level(int unsigned w, int unsigned r);
    return (w + UIRB_RING_DEPTH - r) % UIRB_RING_DEPTH;
  endfunction

  function int unsigned rx_level();
    return level(rx_wr, rx_rd);
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void set_echo(logic value);
    echo_on = value;
  endfunction

  function out_item_t result_of(logic [1:0] kind, logic [7:0] b, logic [1:0] status);
    out_item_t r;
    r = '0;
    r.kind = kind;
    r.out_byte = b;
    r.status = status;
    if (status == STATUS_FULL) n_full++;
    if (status == STATUS_EMPTY) n_empty++;
    return r;
  endfunction

  // Advances the ring state by one accepted request and queues its results.
  function void apply_request(in_item_t req);
    out_item_t   step_q[$];
    logic [7:0]  b;
    int unsigned rx_f, tx_f;
    b = req.data_byte;
    n_requests++;
    case (req.command)
      CMD_PUT: begin
        tx_ie = 1'b1;
        if (next_slot(tx_wr) == tx_rd) begin
          step_q.push_back(result_of(KIND_STATUS, 8'h00, STATUS_FULL));
        end else begin
          tx_store[tx_wr] = b;
          tx_wr = next_slot(tx_wr);
          step_q.push_back(result_of(KIND_STATUS, 8'h00, STATUS_DONE));
        end
      end
      CMD_GET: begin
        rx_ie = 1'b1;
        if (rx_rd == rx_wr) begin
          step_q.push_back(result_of(KIND_STATUS, 8'h00, STATUS_EMPTY));
        end else begin
          step_q.push_back(result_of(KIND_CONSUMER, rx_store[rx_rd], STATUS_DONE));
          rx_rd = next_slot(rx_rd);
        end
      end
      CMD_RX_EVENT: begin
        if (next_slot(rx_wr) == rx_rd) begin
          // A byte arriving on a full ring is lost and never echoed.
          rx_ie = 1'b0;
          step_q.push_back(result_of(KIND_STATUS, 8'h00, STATUS_FULL));
        end else begin
          if (echo_on) begin
            step_q.push_back(result_of(KIND_LINE, b, STATUS_DONE));
            if (b == CH_CR) begin
              n_cr_echo++;
              step_q.push_back(result_of(KIND_LINE, CH_CR, STATUS_DONE));
              step_q.push_back(result_of(KIND_LINE, CH_LF, STATUS_DONE));
            end
          end else begin
            step_q.push_back(result_of(KIND_STATUS, 8'h00, STATUS_DONE));
          end
          rx_store[rx_wr] = (b == CH_CR) ? CH_LF : b;
          rx_wr = next_slot(rx_wr);
          rx_ie = 1'b1;
        end
      end
      default: begin
        if (tx_rd == tx_wr) begin
          tx_ie = 1'b0;
          step_q.push_back(result_of(KIND_STATUS, 8'h00, STATUS_EMPTY));
        end else begin
          step_q.push_back(result_of(KIND_LINE, tx_store[tx_rd], STATUS_DONE));
          tx_rd = next_slot(tx_rd);
          tx_ie = 1'b1;
        end
      end
    endcase
    rx_f = rx_level();
    tx_f = level(tx_wr, tx_rd);
    // Every result of a request reports the state after the whole request.
    foreach (step_q[k]) begin
      step_q[k].rx_irq_enable = rx_ie;
      step_q[k].tx_irq_enable = tx_ie;
      step_q[k].rx_fill = (rx_f > 255) ? 8'd255 : 8'(rx_f);
      step_q[k].tx_fill = (tx_f > 255) ? 8'd255 : 8'(tx_f);
      step_q[k].last = (k == step_q.size() - 1);
      pending_results.push_back(step_q[k]);
    end
  endfunction

  task report(string msg);
    errors++;
    // Only the first mismatches are printed so a broken build cannot flood the log.
    if (errors <= 30) $display("MISMATCH: %s", msg);
  endtask

  task compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report($sformatf("result %0d: %s is 0x%0h, predicted 0x%0h", n_checked, name, got, want));
  endtask

  task check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result with nothing predicted: %p", got));
      return;
    end
    want = pending_results.pop_front();
    n_checked++;
    compare_field("kind", got.kind, want.kind);
    compare_field("out_byte", got.out_byte, want.out_byte);
    compare_field("status", got.status, want.status);
    compare_field("rx_irq_enable", got.rx_irq_enable, want.rx_irq_enable);
    compare_field("tx_irq_enable", got.tx_irq_enable, want.tx_irq_enable);
    compare_field("rx_fill", got.rx_fill, want.rx_fill);
    compare_field("tx_fill", got.tx_fill, want.tx_fill);
    compare_field("last", got.last, want.last);
  endtask
endclass

module tb_top;
  localparam int STALL_LIMIT = 3000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_wr_en;
  logic      cfg_wr_data;

  ring_scoreboard sb;
  bit             in_calm;
  bit             out_calm;

  uart_irq_ring_buffers u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] random_byte();
    // Carriage returns are made common since they take the special echo path.
    if ($urandom_range(7) == 0) return CH_CR;
    return 8'($urandom_range(255));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // Presents one request and returns at the edge where it is taken.
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] b);
    int       gap;
    in_item_t req;
    req.command = cmd;
    req.data_byte = b;
    if ($urandom_range(49) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.apply_request(req);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_request(2'($urandom_range(3)), random_byte());
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_echo(input logic value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_echo(value);
  endtask

  // Fills the receive ring with random bytes and keeps pushing past full a few times.
  task automatic flood_rx_ring();
    int extra;
    extra = 0;
    while (extra < 6) begin
      if ($urandom_range(9) == 0) begin
        send_random(1);
      end else begin
        send_request(CMD_RX_EVENT, random_byte());
      end
      if (sb.rx_level() == UIRB_RING_DEPTH - 1)
        extra++;
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(99) == 0) out_calm = !out_calm;
      if (stall > 0) begin
        stall--;
      end else if (!out_calm && $urandom_range(3) == 0) begin
        stall = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
      out_ready <= (stall == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) sb.check_result(out_data);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: nothing moved on either channel for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Echo on: empty refusals, extreme bytes and an echoed carriage return.
    write_echo(1'b1);
    send_request(CMD_GET, 8'hFF);
    send_request(CMD_TX_READY, 8'h00);
    send_request(CMD_PUT, 8'h00);
    send_request(CMD_PUT, 8'hFF);
    send_request(CMD_PUT, CH_CR);
    send_request(CMD_TX_READY, 8'hA5);
    send_request(CMD_TX_READY, 8'h5A);
    send_request(CMD_TX_READY, 8'hFF);
    send_request(CMD_TX_READY, 8'h00);
    send_request(CMD_RX_EVENT, CH_CR);
    send_request(CMD_RX_EVENT, 8'h00);
    send_request(CMD_RX_EVENT, 8'hFF);
    send_request(CMD_RX_EVENT, CH_LF);
    send_request(CMD_GET, 8'h00);
    send_request(CMD_GET, 8'h5A);
    send_request(CMD_GET, 8'hA5);
    send_request(CMD_GET, 8'hFF);
    send_request(CMD_GET, 8'h00);
    wait_idle();

    // Echo off: drive the receive ring to full, then mixed traffic around full.
    write_echo(1'b0);
    send_request(CMD_RX_EVENT, CH_CR);
    flood_rx_ring();
    send_random(35);
    wait_idle();

    write_echo(1'b1);
    send_random(35);
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Covered %0d requests and %0d results with echo on and off.",
             sb.n_requests, sb.n_checked);
    $display("Saw %0d ring-full refusals, %0d ring-empty refusals, %0d echoed carriage returns.",
             sb.n_full, sb.n_empty, sb.n_cr_echo);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/uirb_pkg.sv
rtl/uirb_cell.sv
rtl/uirb_ring.sv
rtl/uart_irq_ring_buffers.sv
tb/tb_top.sv
